/* sv/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* sv/spq_pkg.sv */
// types, constants and helpers of the stable priority queue
// used by spq_ctrl, spq_dp, the top level and the checker
package spq_pkg;

   localparam int DEPTH      = 64;
   localparam int ID_BITS    = 16;
   localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int PRI_BITS   = 3;
   localparam int MIN_BITS   = 8;
   localparam int WAIT_BITS  = 14;
   localparam int POS_BITS   = 7;
   localparam int FID_BITS   = 16;
   localparam int PROD_BITS  = CNT_BITS + MIN_BITS;
   localparam int CMP_BITS   = PROD_BITS + WAIT_BITS;

   localparam logic [MIN_BITS-1:0]  MINUTES_RESET = MIN_BITS'(10);
   localparam logic [WAIT_BITS-1:0] WAIT_MAX      = {WAIT_BITS{1'b1}};

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_POP    = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_INS_STEP,
      S_INS_LAST,
      S_POP_WAIT,
      S_SRCH_STEP,
      S_MUL,
      S_HEAD_RD,
      S_HEAD_WAIT,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      POS_HOLD,
      POS_ZERO,
      POS_COUNT,
      POS_DEC,
      POS_INC
   } pos_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } cnt_op_type;

   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [PRI_BITS-1:0] pri;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic       load_req;
      pos_op_type pos_op;
      logic       rd_back;
      logic       we;
      logic       wr_new;
      logic       set_status;
      status_type status;
      logic       take_entry;
      logic       set_position;
      logic       do_mul;
      logic       pop_head;
      cnt_op_type cnt_op;
      logic       take_head;
      logic       load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    stop_ins;
      logic    pos_is_one;
      logic    match;
      logic    last;
      logic    out_free;
   } dp_stat_type;

   // logical place -> physical slot of the circular store
   function automatic logic [IDX_BITS-1:0] wrap_addr(input logic [IDX_BITS-1:0] base,
                                                     input logic [CNT_BITS-1:0] offs);
      logic [CNT_BITS:0] sum;
      sum = (CNT_BITS+1)'(base) + (CNT_BITS+1)'(offs);
      if (sum >= (CNT_BITS+1)'(DEPTH)) begin
         sum = sum - (CNT_BITS+1)'(DEPTH);
      end
      return IDX_BITS'(sum);
   endfunction

endpackage

/* sv/stable_priority_queue.sv */
// stable priority queue, one command word at a time, result word registered
// clear, full insert and empty pop, search or insert need no walk; other inserts walk from the
// tail to the new place, a search walks from the head to the hit or the last place
// next word taken in the cycle after the result loads
// reset (synchronous) empties the queue and sets minutes_per_place to 10; no clearing pass
// depends on spq_pkg, spq_ctrl, spq_dp, spq_ram
module stable_priority_queue import spq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_tuser,   // command
   input  logic [23:0]         req_tdata,   // entry_id, entry_priority, zero pad
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [1:0]          rsp_tuser,   // status
   output logic [63:0]         rsp_tdata,   // result_id, result_priority, position,
                                            // wait_minutes, entry_count, is_empty, head_id
   input  logic                csr_we,
   input  logic [MIN_BITS-1:0] csr_wdata    // minutes_per_place
);

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (dp_stat),
      .cmd        (ctrl_cmd)
   );

   spq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (ctrl_cmd),
      .stat       (dp_stat)
   );

endmodule

/* sv/spq_ram.sv */
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/spq_ctrl.sv */
// sequencer of the priority queue: walks each command through its steps
// depends on spq_pkg
module spq_ctrl import spq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_START;
            end
         end
         S_START: begin
            case (stat.cmd)
               CMD_INSERT: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                     state_in       = S_HEAD_RD;
                  end else if (stat.empty) begin
                     cmd.we     = 1'b1;
                     cmd.wr_new = 1'b1;
                     cmd.cnt_op = CNT_INC;
                     state_in   = S_HEAD_RD;
                  end else begin
                     // walk from the tail toward the head
                     cmd.pos_op  = POS_COUNT;
                     cmd.rd_back = 1'b1;
                     state_in    = S_INS_STEP;
                  end
               end
               CMD_POP: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                     state_in       = S_HEAD_RD;
                  end else begin
                     cmd.pos_op = POS_ZERO;
                     state_in   = S_POP_WAIT;
                  end
               end
               CMD_SEARCH: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                     state_in       = S_HEAD_RD;
                  end else begin
                     cmd.pos_op = POS_ZERO;
                     state_in   = S_SRCH_STEP;
                  end
               end
               default: begin
                  cmd.cnt_op = CNT_CLEAR;
                  state_in   = S_HEAD_RD;
               end
            endcase
         end
         S_INS_STEP: begin
            cmd.we = 1'b1;
            if (stat.stop_ins) begin
               cmd.wr_new = 1'b1;
               cmd.cnt_op = CNT_INC;
               state_in   = S_HEAD_RD;
            end else begin
               // move the entry one place back
               cmd.pos_op  = POS_DEC;
               cmd.rd_back = 1'b1;
               if (stat.pos_is_one) begin
                  state_in = S_INS_LAST;
               end
            end
         end
         S_INS_LAST: begin
            cmd.we     = 1'b1;
            cmd.wr_new = 1'b1;
            cmd.cnt_op = CNT_INC;
            state_in   = S_HEAD_RD;
         end
         S_POP_WAIT: begin
            cmd.take_entry = 1'b1;
            cmd.pop_head   = 1'b1;
            cmd.cnt_op     = CNT_DEC;
            state_in       = S_HEAD_RD;
         end
         S_SRCH_STEP: begin
            if (stat.match) begin
               cmd.take_entry   = 1'b1;
               cmd.set_position = 1'b1;
               state_in         = S_MUL;
            end else if (stat.last) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOT_FOUND;
               state_in       = S_HEAD_RD;
            end else begin
               cmd.pos_op = POS_INC;
            end
         end
         S_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = S_HEAD_RD;
         end
         S_HEAD_RD: begin
            cmd.pos_op = POS_ZERO;
            state_in   = S_HEAD_WAIT;
         end
         S_HEAD_WAIT: begin
            cmd.take_head = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* sv/spq_dp.sv */
// datapath of the priority queue: circular entry store, pointers,
// search and wait arithmetic, result word register
// depends on spq_pkg and spq_ram
module spq_dp import spq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               req_tuser,
   input  logic [23:0]              req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [1:0]               rsp_tuser,
   output logic [63:0]              rsp_tdata,
   input  logic                     csr_we,
   input  logic [MIN_BITS-1:0]      csr_wdata,
   input  ctrl_cmd_type             cmd,
   output dp_stat_type              stat
);

   logic [IDX_BITS-1:0]  head_ff, head_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  pos_ff, pos_in;
   cmd_type              op_ff, op_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [PRI_BITS-1:0]  pri_ff, pri_in;
   logic [MIN_BITS-1:0]  minutes_ff, minutes_in;
   status_type           status_ff, status_in;
   logic [FID_BITS-1:0]  rid_ff, rid_in;
   logic [PRI_BITS-1:0]  rpri_ff, rpri_in;
   logic [POS_BITS-1:0]  position_ff, position_in;
   logic [WAIT_BITS-1:0] wait_ff, wait_in;
   logic [FID_BITS-1:0]  head_id_ff, head_id_in;
   logic                 out_valid_ff, out_valid_in;
   logic [1:0]           out_user_ff, out_user_in;
   logic [63:0]          out_data_ff, out_data_in;

   logic [IDX_BITS-1:0]  waddr, raddr;
   logic [CNT_BITS-1:0]  rd_log;
   entry_type            wdata, rdata, new_entry;
   logic [PROD_BITS-1:0] product;

   assign new_entry = '{id: id_ff, pri: pri_ff};
   assign wdata     = cmd.wr_new ? new_entry : rdata;
   assign waddr     = wrap_addr(head_ff, pos_ff);
   assign rd_log    = cmd.rd_back ? CNT_BITS'(pos_in - CNT_BITS'(1)) : pos_in;
   assign raddr     = wrap_addr(head_ff, rd_log);
   assign product   = PROD_BITS'(pos_ff) * PROD_BITS'(minutes_ff);

   spq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (cmd.we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      pri_in       = pri_ff;
      minutes_in   = csr_we ? csr_wdata : minutes_ff;
      status_in    = status_ff;
      rid_in       = rid_ff;
      rpri_in      = rpri_ff;
      position_in  = position_ff;
      wait_in      = wait_ff;
      head_id_in   = head_id_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_user_in  = out_user_ff;
      out_data_in  = out_data_ff;

      if (cmd.load_req) begin
         op_in       = cmd_type'(req_tuser);
         id_in       = ID_BITS'(req_tdata[15:0]);
         pri_in      = req_tdata[18:16];
         pos_in      = '0;
         status_in   = ST_OK;
         rid_in      = '0;
         rpri_in     = '0;
         position_in = '0;
         wait_in     = '0;
      end

      case (cmd.pos_op)
         POS_ZERO:  pos_in = '0;
         POS_COUNT: pos_in = count_ff;
         POS_DEC:   pos_in = pos_ff - CNT_BITS'(1);
         POS_INC:   pos_in = pos_ff + CNT_BITS'(1);
         default:   ;
      endcase

      case (cmd.cnt_op)
         CNT_INC:   count_in = count_ff + CNT_BITS'(1);
         CNT_DEC:   count_in = count_ff - CNT_BITS'(1);
         CNT_CLEAR: count_in = '0;
         default:   ;
      endcase

      if (cmd.pop_head) begin
         head_in = wrap_addr(head_ff, CNT_BITS'(1));
      end
      if (cmd.set_status) begin
         status_in = cmd.status;
      end
      if (cmd.take_entry) begin
         rid_in  = FID_BITS'(rdata.id);
         rpri_in = rdata.pri;
      end
      if (cmd.set_position) begin
         position_in = POS_BITS'((CNT_BITS+1)'(pos_ff) + (CNT_BITS+1)'(1));
      end
      if (cmd.do_mul) begin
         if (CMP_BITS'(product) > CMP_BITS'(WAIT_MAX)) begin
            wait_in = WAIT_MAX;
         end else begin
            wait_in = WAIT_BITS'(product);
         end
      end
      if (cmd.take_head) begin
         head_id_in = (count_ff == '0) ? '0 : FID_BITS'(rdata.id);
      end
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_user_in  = status_ff;
         out_data_in  = {head_id_ff, (count_ff == '0), POS_BITS'(count_ff),
                         wait_ff, position_ff, rpri_ff, rid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         minutes_ff   <= MINUTES_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         minutes_ff   <= minutes_in;
         out_valid_ff <= out_valid_in;
      end
      pos_ff      <= pos_in;
      op_ff       <= op_in;
      id_ff       <= id_in;
      pri_ff      <= pri_in;
      status_ff   <= status_in;
      rid_ff      <= rid_in;
      rpri_ff     <= rpri_in;
      position_ff <= position_in;
      wait_ff     <= wait_in;
      head_id_ff  <= head_id_in;
      out_user_ff <= out_user_in;
      out_data_ff <= out_data_in;
   end

   always_comb begin
      stat.cmd        = op_ff;
      stat.full       = (count_ff == CNT_BITS'(DEPTH));
      stat.empty      = (count_ff == '0);
      stat.stop_ins   = (rdata.pri >= pri_ff);
      stat.pos_is_one = (pos_ff == CNT_BITS'(1));
      stat.match      = (rdata.id == id_ff);
      stat.last       = ((CNT_BITS+1)'(pos_ff) + (CNT_BITS+1)'(1) == (CNT_BITS+1)'(count_ff));
      stat.out_free   = !out_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

/* sv/spq_checker.sv */
// port-level checks of the stable priority queue, bound to the top level
// depends on spq_pkg and assert_macros.svh
`include "assert_macros.svh"

module spq_checker import spq_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic [63:0] rsp_tdata
);

   logic        rsp_stall;
   logic        rsp_fail;
   logic [65:0] rsp_word;
   logic [6:0]  rsp_pos;
   logic [13:0] rsp_wait;
   logic [6:0]  rsp_count;
   logic        rsp_empty;
   logic [15:0] rsp_head;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_fail  = rsp_tvalid && (rsp_tuser != ST_OK);
   assign rsp_word  = {rsp_tuser, rsp_tdata};
   assign rsp_pos   = rsp_tdata[25:19];
   assign rsp_wait  = rsp_tdata[39:26];
   assign rsp_count = rsp_tdata[46:40];
   assign rsp_empty = rsp_tdata[47];
   assign rsp_head  = rsp_tdata[63:48];

   // a stalled result word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // one word in flight: no accept right after an accept
   `ASSERT_NEXT(a_one_at_time, clock, reset, req_tvalid && req_tready, !req_tready)

   // empty flag agrees with the count
   `ASSERT_SAME(a_empty_count, clock, reset, rsp_tvalid, rsp_empty == (rsp_count == 7'd0))

   // empty queue shows no head id
   `ASSERT_SAME(a_empty_head, clock, reset, rsp_tvalid && rsp_empty, rsp_head == 16'd0)

   // failed operations carry no position and no wait
   `ASSERT_SAME(a_fail_zero, clock, reset, rsp_fail, (rsp_pos == 7'd0) && (rsp_wait == 14'd0))

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
